@@ hw/rtl/clcd_pkg.sv @@
// shared types, constants and helpers for the character-lcd text stream nibbler
package clcd_pkg;

    // display geometry
    localparam int COLUMNS = 16;
    localparam int ROWS    = 2;

    // cursor widths
    localparam int COL_W = 6;
    localparam int ROW_W = 2;

    // up to two bytes, two nibbles each, per request
    localparam int NIB_MAX = 4;
    localparam int CNT_W   = 3;

    // request opcodes
    typedef enum logic [1:0] {
        OP_TEXT = 2'd0,
        OP_GOTO = 2'd1,
        OP_DATA = 2'd2,
        OP_CMD  = 2'd3
    } op_t;

    // register-select codes
    localparam logic RS_CMD  = 1'b0;
    localparam logic RS_DATA = 1'b1;

    // special characters and command bits
    localparam logic [7:0] CH_NUL      = 8'h00;
    localparam logic [7:0] CH_NEWLINE  = 8'h0A;
    localparam logic [7:0] CH_RETURN   = 8'h0D;
    localparam logic [7:0] CMD_SET_ADR = 8'h80;

    // one nibble transfer on the display bus
    typedef struct packed {
        logic       rs;
        logic [3:0] nib;
    } nib_ent_t;

    typedef nib_ent_t [NIB_MAX-1:0] nib_buf_t;

    // start address of each display row
    function automatic logic [7:0] row_base(input logic [ROW_W-1:0] row);
        logic [7:0] base;
        begin
            case (row)
                2'd0:    base = 8'h00;
                2'd1:    base = 8'h40;
                2'd2:    base = 8'h14;
                2'd3:    base = 8'h54;
                default: base = 8'h00;
            endcase
            return base;
        end
    endfunction

    // set-address command for a cursor position, address taken mod 256
    function automatic logic [7:0] set_adr(input logic [COL_W-1:0] col,
                                           input logic [ROW_W-1:0] row);
        logic [7:0] sum;
        begin
            sum = 8'({2'b00, col}) + row_base(row);
            return CMD_SET_ADR | sum;
        end
    endfunction

endpackage

@@ hw/rtl/clcd_req_if.sv @@
// request channel: text characters, positioning and raw bytes
interface clcd_req_if;
    logic       valid;
    logic       ready;
    logic [1:0] op;
    logic [7:0] byte_value;
    logic [5:0] target_col;
    logic [2:0] target_row;

    modport source (output valid, op, byte_value, target_col, target_row, input ready);
    modport sink   (input valid, op, byte_value, target_col, target_row, output ready);
endinterface

@@ hw/rtl/clcd_xfer_if.sv @@
// nibble transfer channel toward the display bus
interface clcd_xfer_if;
    logic       valid;
    logic       ready;
    logic       reg_select;
    logic [3:0] nibble;
    logic       last;

    modport source (output valid, reg_select, nibble, last, input ready);
    modport sink   (input valid, reg_select, nibble, last, output ready);
endinterface

@@ hw/rtl/char_lcd_text_stream_nibbler.sv @@
// top level: turns text and positioning requests into 4-bit lcd nibble transfers
//
//  channel | dir | payload                                  | handshake
//  --------+-----+------------------------------------------+-------------
//  req     | in  | op, byte_value, target_col, target_row   | valid/ready
//  xfer    | out | reg_select, nibble, last                 | valid/ready
//
// a request yields 0, 2 or 4 nibble transfers, one per cycle on the output
// register while xfer is ready.
// the cursor is updated in the cycle the request is taken; one pending slot
// behind the output buffer lets the next request in while nibbles still drain.
// reset clears the cursor to column 0, row 0 and empties both buffers.
// a stall on xfer holds the current nibble; req stalls only when the slot is full.
module char_lcd_text_stream_nibbler (
    input  logic              clk,
    input  logic              rst_n,
    clcd_req_if.sink          req,
    clcd_xfer_if.source       xfer
);
    import clcd_pkg::*;

    logic [COL_W-1:0] col_reg, col_next;
    logic [ROW_W-1:0] row_reg, row_next;

    nib_buf_t         act_buf_reg, act_buf_next;
    logic [CNT_W-1:0] act_cnt_reg, act_cnt_next;
    nib_buf_t         pend_buf_reg, pend_buf_next;
    logic [CNT_W-1:0] pend_cnt_reg, pend_cnt_next;
    logic             pend_vld_reg, pend_vld_next;

    logic             fire_in;
    logic             fire_out;
    logic             act_free;

    // decoded request
    op_t              op;
    logic             wrap;
    logic [COL_W-1:0] col0;
    logic [ROW_W-1:0] row0;
    logic [ROW_W-1:0] row_nl;
    logic [ROW_W-1:0] row_go;
    logic             rs_a, rs_b;
    logic [7:0]       byte_a, byte_b;
    logic             two_bytes;
    logic             no_result;
    logic [COL_W-1:0] new_col;
    logic [ROW_W-1:0] new_row;
    nib_buf_t         new_buf;
    logic [CNT_W-1:0] new_cnt;

    assign op       = op_t'(req.op);
    assign fire_in  = req.valid && req.ready;
    assign fire_out = xfer.valid && xfer.ready;
    assign act_free = (act_cnt_reg == '0) ||
                      ((act_cnt_reg == CNT_W'(1)) && fire_out);

    assign req.ready       = !pend_vld_reg;
    assign xfer.valid      = (act_cnt_reg != '0);
    assign xfer.reg_select = act_buf_reg[0].rs;
    assign xfer.nibble     = act_buf_reg[0].nib;
    assign xfer.last       = (act_cnt_reg == CNT_W'(1));

    // cursor after an optional home wrap
    always_comb
    begin
        wrap   = (col_reg >= COL_W'(COLUMNS));
        col0   = wrap ? '0 : col_reg;
        row0   = wrap ? '0 : row_reg;
        row_nl = (({1'b0, row0} + 3'd1) >= 3'(ROWS)) ? '0 : (row0 + ROW_W'(1));
        row_go = (req.target_row >= 3'(ROWS)) ? '0 : req.target_row[ROW_W-1:0];
    end

    // bytes to send and the new cursor
    always_comb
    begin
        no_result = 1'b0;
        two_bytes = 1'b0;
        rs_a      = RS_CMD;
        byte_a    = req.byte_value;
        rs_b      = RS_CMD;
        byte_b    = req.byte_value;
        new_col   = col_reg;
        new_row   = row_reg;
        case (op)
            OP_TEXT:
            begin
                if (req.byte_value == CH_NUL)
                begin
                    no_result = 1'b1;
                end
                else
                begin
                    // home wrap goes first, the main byte second
                    two_bytes = wrap;
                    rs_a      = RS_CMD;
                    byte_a    = CMD_SET_ADR;
                    new_col   = col0;
                    new_row   = row0;
                    if (req.byte_value == CH_NEWLINE)
                    begin
                        rs_b    = RS_CMD;
                        byte_b  = set_adr(col0, row_nl);
                        new_row = row_nl;
                    end
                    else if (req.byte_value == CH_RETURN)
                    begin
                        rs_b    = RS_CMD;
                        byte_b  = set_adr('0, row0);
                        new_col = '0;
                    end
                    else
                    begin
                        rs_b    = RS_DATA;
                        byte_b  = req.byte_value;
                        new_col = col0 + COL_W'(1);
                    end
                    if (!wrap)
                    begin
                        rs_a   = rs_b;
                        byte_a = byte_b;
                    end
                end
            end
            OP_GOTO:
            begin
                rs_a    = RS_CMD;
                byte_a  = set_adr(req.target_col, row_go);
                new_col = req.target_col;
                new_row = row_go;
            end
            OP_DATA:
            begin
                rs_a = RS_DATA;
            end
            default:
            begin
                rs_a = RS_CMD;
            end
        endcase

        new_buf[0] = '{rs: rs_a, nib: byte_a[7:4]};
        new_buf[1] = '{rs: rs_a, nib: byte_a[3:0]};
        new_buf[2] = '{rs: rs_b, nib: byte_b[7:4]};
        new_buf[3] = '{rs: rs_b, nib: byte_b[3:0]};
        if (no_result)
            new_cnt = '0;
        else if (two_bytes)
            new_cnt = CNT_W'(NIB_MAX);
        else
            new_cnt = CNT_W'(2);
    end

    // output buffer, pending slot and cursor
    always_comb
    begin
        col_next      = col_reg;
        row_next      = row_reg;
        act_buf_next  = act_buf_reg;
        act_cnt_next  = act_cnt_reg;
        pend_buf_next = pend_buf_reg;
        pend_cnt_next = pend_cnt_reg;
        pend_vld_next = pend_vld_reg;

        if (fire_in)
        begin
            col_next = new_col;
            row_next = new_row;
        end

        if (fire_out)
        begin
            for (int i = 0; i < NIB_MAX - 1; i++)
                act_buf_next[i] = act_buf_reg[i+1];
            act_cnt_next = act_cnt_reg - CNT_W'(1);
        end

        if (act_free)
        begin
            if (pend_vld_reg)
            begin
                act_buf_next  = pend_buf_reg;
                act_cnt_next  = pend_cnt_reg;
                pend_vld_next = fire_in && !no_result;
                pend_buf_next = new_buf;
                pend_cnt_next = new_cnt;
            end
            else if (fire_in && !no_result)
            begin
                act_buf_next = new_buf;
                act_cnt_next = new_cnt;
            end
        end
        else if (fire_in && !no_result)
        begin
            pend_vld_next = 1'b1;
            pend_buf_next = new_buf;
            pend_cnt_next = new_cnt;
        end
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg      <= '0;
            row_reg      <= '0;
            act_cnt_reg  <= '0;
            pend_vld_reg <= 1'b0;
        end
        else
        begin
            col_reg      <= col_next;
            row_reg      <= row_next;
            act_cnt_reg  <= act_cnt_next;
            pend_vld_reg <= pend_vld_next;
        end
    end

    // payload
    always_ff @(posedge clk)
    begin
        act_buf_reg  <= act_buf_next;
        pend_buf_reg <= pend_buf_next;
        pend_cnt_reg <= pend_cnt_next;
    end

endmodule

@@ dv/testbench.sv @@
// testbench for the character-lcd text stream nibbler: directed and random requests
`timescale 1ns / 1ps

module testbench;
    import clcd_pkg::*;

    localparam int IDLE_LIMIT   = 1000;
    localparam int DRAIN_CYCLES = 8;
    localparam int MAX_REPORTS  = 10;

    // display row start addresses
    localparam logic [7:0] ROW_START [4] = '{8'h00, 8'h40, 8'h14, 8'h54};

    // one expected nibble transfer
    typedef struct {
        logic       rs;
        logic [3:0] nib;
        logic       last;
    } lcd_xfer_t;

    logic clk = 1'b0;
    logic rst_n;

    clcd_req_if  req_bus ();
    clcd_xfer_if nib_bus ();

    char_lcd_text_stream_nibbler dut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_bus),
        .xfer  (nib_bus)
    );

    // predicted cursor and pending nibble transfers
    logic [5:0] cursor_col = '0;
    logic [1:0] cursor_row = '0;
    lcd_xfer_t  nibbles_due[$];

    // run bookkeeping
    int  fail_cnt     = 0;
    int  n_req        = 0;
    int  n_xfer       = 0;
    int  n_home_wraps = 0;
    int  op_seen [4]  = '{0, 0, 0, 0};
    int  idle_cycles  = 0;
    int  stall_left   = 0;
    bit  src_idle_on  = 1'b0;
    bit  snk_idle_on  = 1'b0;

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    function automatic logic [7:0] set_address_byte(input logic [5:0] col,
                                                    input logic [1:0] row);
        return CMD_SET_ADR | (8'(col) + ROW_START[row]);
    endfunction

    // cursor tracking and byte expansion for one accepted request
    function automatic void predict_transfers(input op_t op, input logic [7:0] b,
                                              input logic [5:0] tc, input logic [2:0] tr);
        logic [7:0]  bytes [$];
        logic        sel [$];
        int unsigned nrow;
        lcd_xfer_t   e;
        case (op)
            OP_TEXT:
            begin
                if (b != CH_NUL)
                begin
                    // past the last column: home first
                    if (cursor_col >= COLUMNS)
                    begin
                        cursor_col = '0;
                        cursor_row = '0;
                        bytes.push_back(set_address_byte('0, '0));
                        sel.push_back(RS_CMD);
                        n_home_wraps++;
                    end
                    if (b == CH_NEWLINE)
                    begin
                        nrow = cursor_row + 1;
                        if (nrow >= ROWS)
                            nrow = 0;
                        cursor_row = nrow[1:0];
                        bytes.push_back(set_address_byte(cursor_col, cursor_row));
                        sel.push_back(RS_CMD);
                    end
                    else if (b == CH_RETURN)
                    begin
                        cursor_col = '0;
                        bytes.push_back(set_address_byte(cursor_col, cursor_row));
                        sel.push_back(RS_CMD);
                    end
                    else
                    begin
                        bytes.push_back(b);
                        sel.push_back(RS_DATA);
                        cursor_col = cursor_col + 6'd1;
                    end
                end
            end
            OP_GOTO:
            begin
                cursor_col = tc;
                cursor_row = (tr >= ROWS) ? 2'd0 : tr[1:0];
                bytes.push_back(set_address_byte(cursor_col, cursor_row));
                sel.push_back(RS_CMD);
            end
            OP_DATA:
            begin
                bytes.push_back(b);
                sel.push_back(RS_DATA);
            end
            default:
            begin
                bytes.push_back(b);
                sel.push_back(RS_CMD);
            end
        endcase
        // high nibble first, last flag on the final nibble
        foreach (bytes[i])
        begin
            e.rs   = sel[i];
            e.nib  = bytes[i][7:4];
            e.last = 1'b0;
            nibbles_due.push_back(e);
            e.nib  = bytes[i][3:0];
            e.last = (i == bytes.size() - 1);
            nibbles_due.push_back(e);
        end
    endfunction

    function automatic void log_fail(input string msg);
        fail_cnt++;
        if (fail_cnt <= MAX_REPORTS)
            $display("[%0t] mismatch: %s", $realtime, msg);
    endfunction

    // output check first, then prediction of the request taken at this edge
    always @(posedge clk)
    begin
        lcd_xfer_t e;
        bit        moved;
        if (rst_n)
        begin
            moved = 1'b0;
            if (nib_bus.valid && nib_bus.ready)
            begin
                moved = 1'b1;
                n_xfer++;
                stall_left = snk_idle_on ? $urandom_range(0, 3) : 0;
                if (nibbles_due.size() == 0)
                    log_fail($sformatf("unexpected transfer rs=%0b nib=%h last=%0b",
                                       nib_bus.reg_select, nib_bus.nibble, nib_bus.last));
                else
                begin
                    e = nibbles_due.pop_front();
                    if (nib_bus.reg_select !== e.rs || nib_bus.nibble !== e.nib ||
                        nib_bus.last !== e.last)
                        log_fail($sformatf(
                            "transfer %0d exp rs=%0b nib=%h last=%0b, got rs=%0b nib=%h last=%0b",
                            n_xfer, e.rs, e.nib, e.last, nib_bus.reg_select,
                            nib_bus.nibble, nib_bus.last));
                end
            end
            if (req_bus.valid && req_bus.ready)
            begin
                moved = 1'b1;
                n_req++;
                op_seen[req_bus.op]++;
                predict_transfers(op_t'(req_bus.op), req_bus.byte_value,
                                  req_bus.target_col, req_bus.target_row);
            end
            idle_cycles = moved ? 0 : idle_cycles + 1;
        end
    end

    // watchdog on a stuck handshake
    initial
    begin
        wait (idle_cycles >= IDLE_LIMIT);
        $display("no transfer for %0d cycles", IDLE_LIMIT);
        $display("testbench failed");
        $finish;
    end

    // sink side: random stall after each transfer while sink idling is on
    initial
    begin
        nib_bus.ready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (stall_left > 0)
            begin
                nib_bus.ready <= 1'b0;
                stall_left--;
            end
            else
                nib_bus.ready <= 1'b1;
        end
    end

    // one request: optional gap, then hold until taken
    task automatic send_req(input op_t op, input logic [7:0] b,
                            input logic [5:0] tc, input logic [2:0] tr);
        int gap;
        gap = src_idle_on ? $urandom_range(0, 3) : 0;
        repeat (gap)
        begin
            @(negedge clk);
            req_bus.valid <= 1'b0;
        end
        @(negedge clk);
        req_bus.valid      <= 1'b1;
        req_bus.op         <= op;
        req_bus.byte_value <= b;
        req_bus.target_col <= tc;
        req_bus.target_row <= tr;
        do
            @(posedge clk);
        while (!req_bus.ready);
    endtask

    // byte requests carry random content in the unused position fields
    task automatic send_byte(input op_t op, input logic [7:0] b);
        send_req(op, b, 6'($urandom), 3'($urandom));
    endtask

    task automatic send_goto(input logic [5:0] col, input logic [2:0] row);
        send_req(OP_GOTO, 8'($urandom), col, row);
    endtask

    // drop valid and let every pending nibble come out
    task automatic drain;
        @(negedge clk);
        req_bus.valid <= 1'b0;
        while (nibbles_due.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    // plain text: nul, printable, top byte, newline with row wrap, carriage return
    task automatic test_text_basics;
        src_idle_on = 1'b0;
        snk_idle_on = 1'b0;
        send_byte(OP_TEXT, CH_NUL);
        send_byte(OP_TEXT, 8'h41);
        send_byte(OP_TEXT, 8'hFF);
        send_byte(OP_TEXT, CH_NEWLINE);
        send_byte(OP_TEXT, CH_NEWLINE);
        send_byte(OP_TEXT, CH_RETURN);
        drain();
    endtask

    // positioning: out-of-range rows, columns past the edge, wrap home
    task automatic test_goto_edges;
        src_idle_on = 1'b1;
        snk_idle_on = 1'b1;
        send_goto(6'd63, 3'd7);
        send_byte(OP_TEXT, 8'h78);
        send_goto(6'(COLUMNS - 1), 3'd1);
        send_byte(OP_TEXT, 8'h61);
        send_byte(OP_TEXT, CH_NEWLINE);
        send_goto(6'(COLUMNS), 3'd0);
        send_byte(OP_TEXT, CH_RETURN);
        send_goto(6'd0, 3'd3);
        send_goto(6'd0, 3'd1);
        drain();
    endtask

    // raw data and commands leave the cursor alone
    task automatic test_raw_bytes;
        src_idle_on = 1'b0;
        snk_idle_on = 1'b1;
        send_byte(OP_DATA, 8'h00);
        send_byte(OP_DATA, 8'hFF);
        send_byte(OP_DATA, 8'hA5);
        send_byte(OP_CMD, 8'h01);
        send_byte(OP_CMD, 8'h0F);
        send_byte(OP_CMD, 8'hFF);
        send_byte(OP_CMD, 8'h00);
        send_byte(OP_TEXT, 8'h5A);
        drain();
    endtask

    // mixed stream weighted toward text, idling switched per block
    task automatic test_random_stream(input int n_items);
        int pick;
        for (int i = 0; i < n_items; i++)
        begin
            if (i % 50 == 0)
            begin
                src_idle_on = ($urandom_range(0, 3) != 0);
                snk_idle_on = ($urandom_range(0, 3) != 0);
            end
            pick = $urandom_range(0, 99);
            if (pick < 40)
                send_byte(OP_TEXT, 8'($urandom_range(8'h20, 8'h7E)));
            else if (pick < 48)
                send_byte(OP_TEXT, 8'($urandom));
            else if (pick < 54)
                send_byte(OP_TEXT, CH_NEWLINE);
            else if (pick < 60)
                send_byte(OP_TEXT, CH_RETURN);
            else if (pick < 72)
            begin
                if ($urandom_range(0, 3) == 0)
                    send_goto(6'($urandom), 3'($urandom));
                else
                    send_goto(6'($urandom_range(0, COLUMNS)), 3'($urandom));
            end
            else if (pick < 86)
                send_byte(OP_DATA, 8'($urandom));
            else
                send_byte(OP_CMD, 8'($urandom));
        end
        drain();
    endtask

    initial
    begin
        rst_n              = 1'b0;
        req_bus.valid      = 1'b0;
        req_bus.op         = OP_TEXT;
        req_bus.byte_value = '0;
        req_bus.target_col = '0;
        req_bus.target_row = '0;
        repeat (5) @(negedge clk);
        rst_n <= 1'b1;

        test_text_basics();
        test_goto_edges();
        test_raw_bytes();
        test_random_stream(500);

        $display("%0d requests (text %0d, goto %0d, data %0d, cmd %0d), %0d nibbles",
                 n_req, op_seen[OP_TEXT], op_seen[OP_GOTO], op_seen[OP_DATA],
                 op_seen[OP_CMD], n_xfer);
        $display("%0d wraps to home, %0d mismatches", n_home_wraps, fail_cnt);
        if (fail_cnt == 0)
            $display("testbench passed");
        else
            $display("testbench failed");
        $finish;
    end

endmodule

@@ sim.f @@
hw/rtl/clcd_pkg.sv
hw/rtl/clcd_req_if.sv
hw/rtl/clcd_xfer_if.sv
hw/rtl/char_lcd_text_stream_nibbler.sv
dv/testbench.sv
